// ----- rtl/core/mbi_pkg.sv -----
package mbi_pkg;

   localparam int PendingSlotsDefault = 8;

   typedef enum logic [2:0] {
      OP_REQUEST = 3'd0,
      OP_RELEASE = 3'd1,
      OP_SET_IDLE = 3'd2,
      OP_FINAL_CMD = 3'd3,
      OP_CMD_STATUS = 3'd4,
      OP_HW_FRAME = 3'd5
   } opcode_type;

   localparam logic [7:0] ST_SENT = 8'd1;
   localparam logic [7:0] ST_ACKED = 8'd2;
   localparam logic [7:0] ST_REJECTED = 8'd3;
   localparam logic [7:0] ST_TIMED_OUT = 8'd4;
   localparam logic [7:0] ST_LOST = 8'd7;
   localparam logic [7:0] ST_SUPERSEDED = 8'd8;

   localparam logic [2:0] FAIL_NONE = 3'd0;
   localparam logic [2:0] FAIL_REJECTED = 3'd1;
   localparam logic [2:0] FAIL_TIMED_OUT = 3'd2;
   localparam logic [2:0] FAIL_LOST = 3'd3;
   localparam logic [2:0] FAIL_SUPERSEDED = 3'd4;
   localparam logic [2:0] FAIL_OVERFLOW = 3'd5;

   localparam logic [3:0] BLK_INACTIVE = 4'd0;
   localparam logic [3:0] BLK_MISSION_BUSY = 4'd6;
   localparam logic [3:0] BLK_GATE_NOT_APPLIED = 4'd7;
   localparam logic [3:0] BLK_ACK_PENDING = 4'd8;
   localparam logic [3:0] BLK_HW_PENDING = 4'd9;
   localparam logic [3:0] BLK_HW_NOT_FRESH = 4'd10;
   localparam logic [3:0] BLK_NOT_STOPPED = 4'd11;
   localparam logic [3:0] BLK_BRUSH_ON = 4'd12;
   localparam logic [3:0] BLK_CONFIRM_PENDING = 4'd13;
   localparam logic [3:0] BLK_READY = 4'd14;

   // request from sequencer to slot table
   typedef struct packed {
      logic        start;
      logic        clear_all;
      logic [63:0] cmd;
   } scan_req_type;

   // result of a slot table scan
   typedef struct packed {
      logic       done;
      logic       hit;
      logic       free_found;
      logic       hit_acked;
      logic [2:0] hit_failure;
   } scan_rsp_type;

   // write request to slot table after scan
   typedef struct packed {
      logic       remember;
      logic       consume;
      logic       acked;
      logic [2:0] failure;
   } slot_upd_type;

   function automatic logic [2:0] failure_of(input logic [7:0] st);
      logic [2:0] f;
      begin
         f = FAIL_NONE;
         case (st)
            ST_REJECTED: f = FAIL_REJECTED;
            ST_TIMED_OUT: f = FAIL_TIMED_OUT;
            ST_LOST: f = FAIL_LOST;
            ST_SUPERSEDED: f = FAIL_SUPERSEDED;
            default: f = FAIL_NONE;
         endcase
         return f;
      end
   endfunction

endpackage

// ----- rtl/core/mbi_slot_table.sv -----
module mbi_slot_table #(
   parameter int PENDING_SLOTS = mbi_pkg::PendingSlotsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbi_pkg::scan_req_type scan_req,
   output mbi_pkg::scan_rsp_type scan_rsp,
   input  mbi_pkg::slot_upd_type slot_upd
);
   import mbi_pkg::*;

   localparam int IdxW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam int CntW = $clog2(PENDING_SLOTS + 1);

   logic [PENDING_SLOTS-1:0] valid_ff, valid_in;
   logic [63:0] cmd_mem [PENDING_SLOTS];
   logic        acked_mem [PENDING_SLOTS];
   logic [2:0]  fail_mem [PENDING_SLOTS];

   logic            busy_ff, busy_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic            hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic            free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic            done_ff, done_in;
   logic [63:0]     rd_cmd_ff;
   logic            rd_valid_ff;
   logic            rd_stage_ff, rd_stage_in;
   logic [IdxW-1:0] rd_idx_ff;
   logic [IdxW-1:0] pos_idx;
   logic [IdxW-1:0] wr_idx;

   assign pos_idx = pos_ff[IdxW-1:0];
   assign wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   // registered memory read, one slot a cycle
   always_ff @(posedge clock) begin
      rd_cmd_ff <= cmd_mem[pos_idx];
      rd_idx_ff <= pos_idx;
      rd_valid_ff <= valid_ff[pos_idx];
   end

   // memory writes after the scan
   always_ff @(posedge clock) begin
      if (slot_upd.remember) begin
         if (!hit_ff) begin
            cmd_mem[wr_idx] <= scan_req.cmd;
         end
         if (slot_upd.failure != FAIL_NONE) begin
            fail_mem[wr_idx] <= slot_upd.failure;
            acked_mem[wr_idx] <= 1'b0;
         end else begin
            if (!hit_ff) begin
               fail_mem[wr_idx] <= FAIL_NONE;
            end
            acked_mem[wr_idx] <= (hit_ff ? acked_mem[wr_idx] : 1'b0)
               | (slot_upd.acked & (!hit_ff || fail_mem[wr_idx] == FAIL_NONE));
         end
      end
   end

   // scan sequencing: issue address, compare registered data next cycle
   always_comb begin
      busy_in = busy_ff;
      pos_in = pos_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      done_in = 1'b0;
      rd_stage_in = 1'b0;
      valid_in = valid_ff;
      if (scan_req.start) begin
         busy_in = 1'b1;
         pos_in = '0;
         hit_in = 1'b0;
         free_in = 1'b0;
      end else if (busy_ff) begin
         rd_stage_in = 1'b1;
         if (pos_ff == CntW'(PENDING_SLOTS - 1)) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (rd_stage_ff) begin
         if (rd_valid_ff && rd_cmd_ff == scan_req.cmd && !hit_in) begin
            hit_in = 1'b1;
            hit_idx_in = rd_idx_ff;
         end
         if (!rd_valid_ff && !free_in) begin
            free_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if (!busy_ff) begin
            done_in = 1'b1;
         end
      end
      if (slot_upd.remember) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (slot_upd.consume) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
      if (scan_req.clear_all) begin
         valid_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rd_stage_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         rd_stage_ff <= rd_stage_in;
      end
      pos_ff <= pos_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
   end

   assign scan_rsp.done = done_ff;
   assign scan_rsp.hit = hit_ff;
   assign scan_rsp.free_found = free_ff;
   assign scan_rsp.hit_acked = acked_mem[hit_idx_ff];
   assign scan_rsp.hit_failure = fail_mem[hit_idx_ff];

endmodule

// ----- rtl/core/maintenance_brake_interlock.sv -----
// channel | direction | tdata fields (low bit up)                     | tuser
// req     | in        | tag, second_tag, from_gate_source, cmd_ident,  | opcode
//         |           | flag_a, flag_b, linear_speed, angular_speed,   |
//         |           | brush_rate, status_state (pad to 256)          |
// rsp     | out       | accepted, ready_res, blocker,                  | -
//         |           | current_generation (pad to 72)                 |
// request, release, idle, unused, ignored and epoch zero events go from the
// execute state to the output state; a hardware frame of the current
// or a newer epoch passes through the finish state first
// a safe final command, or a status for a command other than the tracked one,
// searches the pending table one slot a cycle in the scan and wait states
// req_tready is low in reset and from accept until the result has been taken
module maintenance_brake_interlock #(
   parameter int PENDING_SLOTS = mbi_pkg::PendingSlotsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tag, second_tag, from_gate_source, cmd_ident, flag_a, flag_b,
   // linear_speed, angular_speed, brush_rate, status_state
   input  logic [255:0] req_tdata,
   // opcode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted, ready_res, blocker, current_generation
   output logic [71:0]  rsp_tdata
);
   import mbi_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_WAIT   = 6'b001000,
      S_FINISH = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // captured item
   logic [2:0]  op_ff;
   logic [63:0] tag_ff, tag2_ff, cmd_ff;
   logic        src_ff, fa_ff, fb_ff, lz_ff, az_ff, bz_ff;
   logic [7:0]  st_ff;

   // interlock state
   logic        gate_on_ff, gate_on_in;
   logic [63:0] active_gen_ff, active_gen_in;
   logic [63:0] highest_gen_ff, highest_gen_in;
   logic        idle_ff, idle_in;
   logic        applied_ff, applied_in;
   logic [63:0] tracked_ff, tracked_in;
   logic        acked_ff, acked_in;
   logic [2:0]  fail_ff, fail_in;
   logic        hw_seen_ff, hw_seen_in;
   logic        fresh_ff, fresh_in;
   logic        lin_ff, lin_in, ang_ff, ang_in, brush_ff, brush_in;
   logic [1:0]  zf_ff, zf_in;
   logic        ek_ff, ek_in;
   logic [63:0] es_ff, es_in;
   logic        sk_ff, sk_in;
   logic [63:0] ss_ff, ss_in;
   logic        accepted_ff, accepted_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   scan_req_type scan_req;
   scan_rsp_type scan_rsp;
   slot_upd_type slot_upd;

   logic        evid_ok, safe, st_acked, changed;
   logic [2:0]  st_fail;
   logic        ready;
   logic [3:0]  blk;

   mbi_slot_table #(.PENDING_SLOTS(PENDING_SLOTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp),
      .slot_upd (slot_upd)
   );

   assign req_tready = state_ff == S_IDLE && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign evid_ok = tag_ff == active_gen_ff && tag2_ff == active_gen_ff && src_ff;
   assign safe = fa_ff && fb_ff && cmd_ff != '0 && lz_ff && az_ff && bz_ff;
   assign st_acked = st_ff == ST_SENT || st_ff == ST_ACKED;
   assign st_fail = failure_of(st_ff);
   assign changed = !applied_ff || cmd_ff != tracked_ff;

   // readiness snapshot from current state
   always_comb begin
      ready = gate_on_ff && idle_ff && applied_ff && acked_ff && fail_ff == FAIL_NONE
         && hw_seen_ff && fresh_ff && lin_ff && ang_ff && brush_ff && zf_ff == 2'd2;
      if (!gate_on_ff) blk = BLK_INACTIVE;
      else if (fail_ff != FAIL_NONE) blk = {1'b0, fail_ff};
      else if (!idle_ff) blk = BLK_MISSION_BUSY;
      else if (!applied_ff) blk = BLK_GATE_NOT_APPLIED;
      else if (!acked_ff) blk = BLK_ACK_PENDING;
      else if (!hw_seen_ff) blk = BLK_HW_PENDING;
      else if (!fresh_ff) blk = BLK_HW_NOT_FRESH;
      else if (!lin_ff || !ang_ff) blk = BLK_NOT_STOPPED;
      else if (!brush_ff) blk = BLK_BRUSH_ON;
      else if (zf_ff != 2'd2) blk = BLK_CONFIRM_PENDING;
      else blk = BLK_READY;
   end

   // event sequencer
   always_comb begin
      logic clr_conf, clr_evid, do_latch, note;
      logic [2:0] latch_kind;
      logic [63:0] note_val;
      clr_conf = 1'b0;
      clr_evid = 1'b0;
      do_latch = 1'b0;
      latch_kind = FAIL_NONE;
      note = 1'b0;
      note_val = tag2_ff;
      state_in = state_ff;
      gate_on_in = gate_on_ff;
      active_gen_in = active_gen_ff;
      highest_gen_in = highest_gen_ff;
      idle_in = idle_ff;
      applied_in = applied_ff;
      tracked_in = tracked_ff;
      acked_in = acked_ff;
      fail_in = fail_ff;
      hw_seen_in = hw_seen_ff;
      fresh_in = fresh_ff;
      lin_in = lin_ff;
      ang_in = ang_ff;
      brush_in = brush_ff;
      zf_in = zf_ff;
      ek_in = ek_ff;
      es_in = es_ff;
      sk_in = sk_ff;
      ss_in = ss_ff;
      accepted_in = accepted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      scan_req.start = 1'b0;
      scan_req.clear_all = 1'b0;
      scan_req.cmd = cmd_ff;
      slot_upd = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
               accepted_in = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            case (op_ff)
               OP_REQUEST: begin
                  if (tag_ff != '0 && tag_ff > highest_gen_ff) begin
                     gate_on_in = 1'b1;
                     active_gen_in = tag_ff;
                     highest_gen_in = tag_ff;
                     idle_in = fa_ff;
                     clr_evid = 1'b1;
                     accepted_in = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (gate_on_ff && tag_ff == active_gen_ff) begin
                     gate_on_in = 1'b0;
                     active_gen_in = '0;
                     idle_in = 1'b0;
                     clr_evid = 1'b1;
                     accepted_in = 1'b1;
                  end
               end
               OP_SET_IDLE: idle_in = fa_ff;
               OP_FINAL_CMD: begin
                  if (gate_on_ff && fail_ff == FAIL_NONE && evid_ok) begin
                     if (!safe) begin
                        applied_in = 1'b0;
                        tracked_in = '0;
                        acked_in = 1'b0;
                        clr_conf = 1'b1;
                     end else begin
                        applied_in = 1'b1;
                        if (changed) begin
                           tracked_in = cmd_ff;
                           acked_in = 1'b0;
                           clr_conf = 1'b1;
                        end
                        scan_req.start = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
               end
               OP_CMD_STATUS: begin
                  if (gate_on_ff && fail_ff == FAIL_NONE && evid_ok && cmd_ff != '0
                      && (st_acked || st_fail != FAIL_NONE)) begin
                     if (applied_ff && cmd_ff == tracked_ff) begin
                        if (st_fail != FAIL_NONE) begin
                           do_latch = 1'b1;
                           latch_kind = st_fail;
                        end else if (!acked_ff) begin
                           acked_in = 1'b1;
                           clr_conf = 1'b1;
                        end
                     end else begin
                        scan_req.start = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
               end
               OP_HW_FRAME: begin
                  if (gate_on_ff && fail_ff == FAIL_NONE) begin
                     if (tag_ff == '0) begin
                        clr_conf = 1'b1;
                     end else if (!ek_ff || tag_ff >= es_ff) begin
                        // newer epoch restarts the sequence tracking
                        state_in = S_FINISH;
                        if (!ek_ff || tag_ff > es_ff) begin
                           clr_conf = 1'b1;
                           ek_in = 1'b1;
                           es_in = tag_ff;
                           sk_in = 1'b0;
                           ss_in = '0;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: state_in = S_WAIT;
         S_WAIT: begin
            if (scan_rsp.done) begin
               state_in = S_OUT;
               if (op_ff == OP_FINAL_CMD) begin
                  if (scan_rsp.hit) begin
                     slot_upd.consume = 1'b1;
                     if (scan_rsp.hit_failure != FAIL_NONE) begin
                        do_latch = 1'b1;
                        latch_kind = scan_rsp.hit_failure;
                     end else if (scan_rsp.hit_acked && !acked_ff) begin
                        acked_in = 1'b1;
                        clr_conf = 1'b1;
                     end
                  end
               end else if (!scan_rsp.hit && !scan_rsp.free_found) begin
                  do_latch = 1'b1;
                  latch_kind = FAIL_OVERFLOW;
               end else begin
                  slot_upd.remember = 1'b1;
                  slot_upd.acked = st_acked;
                  slot_upd.failure = st_fail;
               end
            end
         end
         S_FINISH: begin
            // hardware frame evaluation for a current epoch
            state_in = S_OUT;
            if (!acked_ff) begin
               note = 1'b1;
            end else if (!(fa_ff && fb_ff && lz_ff && az_ff && bz_ff)) begin
               hw_seen_in = 1'b1;
               fresh_in = fa_ff && fb_ff;
               lin_in = lz_ff;
               ang_in = az_ff;
               brush_in = bz_ff;
               zf_in = 2'd0;
               note = 1'b1;
            end else if (!sk_ff || tag2_ff > ss_ff) begin
               hw_seen_in = 1'b1;
               fresh_in = 1'b1;
               lin_in = 1'b1;
               ang_in = 1'b1;
               brush_in = 1'b1;
               sk_in = 1'b1;
               ss_in = tag2_ff;
               if (zf_ff != 2'd2) zf_in = zf_ff + 2'd1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, active_gen_ff, blk, ready, accepted_ff};
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (note && (!sk_ff || note_val > ss_ff)) begin
         sk_in = 1'b1;
         ss_in = note_val;
      end
      if (do_latch) begin
         fail_in = latch_kind;
         acked_in = 1'b0;
         clr_conf = 1'b1;
         scan_req.clear_all = 1'b1;
      end
      if (clr_evid) begin
         applied_in = 1'b0;
         tracked_in = '0;
         acked_in = 1'b0;
         fail_in = FAIL_NONE;
         clr_conf = 1'b1;
         scan_req.clear_all = 1'b1;
         ek_in = 1'b0;
         es_in = '0;
         sk_in = 1'b0;
         ss_in = '0;
      end
      if (clr_conf) begin
         hw_seen_in = 1'b0;
         fresh_in = 1'b0;
         lin_in = 1'b0;
         ang_in = 1'b0;
         brush_in = 1'b0;
         zf_in = 2'd0;
      end
      // epoch zero frame: confirmation follows brake ack
      if (state_ff == S_EXEC && op_ff == OP_HW_FRAME && gate_on_ff
          && fail_ff == FAIL_NONE && tag_ff == '0) begin
         hw_seen_in = acked_ff;
      end
   end

   // capture accepted transfer
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff <= req_tuser;
         tag_ff <= req_tdata[63:0];
         tag2_ff <= req_tdata[127:64];
         src_ff <= req_tdata[128];
         cmd_ff <= req_tdata[192:129];
         fa_ff <= req_tdata[193];
         fb_ff <= req_tdata[194];
         lz_ff <= req_tdata[210:195] == '0;
         az_ff <= req_tdata[226:211] == '0;
         bz_ff <= req_tdata[242:227] == '0;
         st_ff <= req_tdata[250:243];
      end
      rsp_data_ff <= rsp_data_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gate_on_ff <= 1'b0;
         active_gen_ff <= '0;
         highest_gen_ff <= '0;
         idle_ff <= 1'b0;
         applied_ff <= 1'b0;
         tracked_ff <= '0;
         acked_ff <= 1'b0;
         fail_ff <= FAIL_NONE;
         hw_seen_ff <= 1'b0;
         fresh_ff <= 1'b0;
         lin_ff <= 1'b0;
         ang_ff <= 1'b0;
         brush_ff <= 1'b0;
         zf_ff <= 2'd0;
         ek_ff <= 1'b0;
         es_ff <= '0;
         sk_ff <= 1'b0;
         ss_ff <= '0;
         accepted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gate_on_ff <= gate_on_in;
         active_gen_ff <= active_gen_in;
         highest_gen_ff <= highest_gen_in;
         idle_ff <= idle_in;
         applied_ff <= applied_in;
         tracked_ff <= tracked_in;
         acked_ff <= acked_in;
         fail_ff <= fail_in;
         hw_seen_ff <= hw_seen_in;
         fresh_ff <= fresh_in;
         lin_ff <= lin_in;
         ang_ff <= ang_in;
         brush_ff <= brush_in;
         zf_ff <= zf_in;
         ek_ff <= ek_in;
         es_ff <= es_in;
         sk_ff <= sk_in;
         ss_ff <= ss_in;
         accepted_ff <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a result is only offered while the sequencer sits in the output state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT)
      else $error("result offered outside output state");

   // a latched failure always leaves the brake unacknowledged
   assert property (@(posedge clock) disable iff (reset)
      fail_ff != FAIL_NONE |-> !acked_ff)
      else $error("failure latched with brake acknowledged");

   // the active generation never exceeds the highest one seen
   assert property (@(posedge clock) disable iff (reset)
      active_gen_ff <= highest_gen_ff)
      else $error("active generation above highest");
`endif

endmodule
